### rtl/iext_pkg.sv
// Package for the immediate-extension unit: operation codes, prefix state type,
// stream payload widths. No dependencies.

package iext_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned FIELD_W  = 13;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SIZE_W   = 3;
  localparam int unsigned PREFIX_W = 13;

  // Packed stream layouts, padded to whole bytes.
  localparam int unsigned IN_BITS   = FUNC_W + FIELD_W + WORD_W + SIZE_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = WORD_W + 1;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_PREFIX = 3'd0,
    FUNC_IMM6        = 3'd1,
    FUNC_SIGN6       = 3'd2,
    FUNC_REG_DISP    = 3'd3,
    FUNC_SP_IMM6     = 3'd4,
    FUNC_THREE_OP    = 3'd5,
    FUNC_PC_SIGN8    = 3'd6,
    FUNC_NOP         = 3'd7
  } func_t;

  // Two pending prefix slots; the second is only ever valid with the first.
  typedef struct packed {
    logic                first_valid;
    logic [PREFIX_W-1:0] first_bits;
    logic                second_valid;
    logic [PREFIX_W-1:0] second_bits;
  } prefix_state_t;

  // One decoded operation as held in the input register.
  typedef struct packed {
    func_t              func;
    logic [FIELD_W-1:0] field_bits;
    logic [WORD_W-1:0]  base_value;
    logic [SIZE_W-1:0]  access_size;
  } op_t;

endpackage

### rtl/iext_datapath.sv
// Combinational datapath of the immediate-extension unit: builds the value for
// one operation from the pending prefixes and computes the next prefix state.
// Depends on iext_pkg.

module iext_datapath (
  input  iext_pkg::op_t                      op,
  input  iext_pkg::prefix_state_t            pfx,
  output logic [iext_pkg::WORD_W-1:0]        result_value,
  output logic                               error,
  output iext_pkg::prefix_state_t            pfx_nxt
);

  logic [5:0]                       imm6;
  logic [7:0]                       s8;
  logic [iext_pkg::PREFIX_W-1:0]    f;
  logic [iext_pkg::PREFIX_W-1:0]    s;
  logic                             two;
  logic                             one;
  logic                             any;
  logic [iext_pkg::WORD_W-1:0]      b6;
  logic [iext_pkg::WORD_W-1:0]      sg6;
  logic [iext_pkg::WORD_W-1:0]      b13;
  logic [8:0]                       scaled;
  logic [iext_pkg::WORD_W-1:0]      disp;
  logic [iext_pkg::WORD_W-1:0]      addend;
  logic [iext_pkg::WORD_W-1:0]      sum;

  assign imm6 = op.field_bits[5:0];
  assign s8   = op.field_bits[7:0];
  assign f    = pfx.first_bits;
  assign s    = pfx.second_bits;
  assign two  = pfx.second_valid;
  assign one  = pfx.first_valid & ~pfx.second_valid;
  assign any  = pfx.first_valid | pfx.second_valid;

  // Low immediate with prefixes stacked above it.
  assign b6  = two ? {f, s, imm6}
             : one ? {13'd0, f, imm6}
             : {26'd0, imm6};
  assign sg6 = two ? {f, s, imm6}
             : one ? {{13{f[12]}}, f, imm6}
             : {{26{imm6[5]}}, imm6};
  assign b13 = two ? {6'd0, f, s}
             : one ? {19'd0, f}
             : '0;

  assign scaled = 9'(imm6) * 9'(op.access_size);

  // Branch displacement before doubling; low three bits of the first prefix dropped.
  assign disp = two ? {f[12], f[12:3], s, s8}
              : one ? {{11{f[12]}}, f, s8}
              : {{24{s8[7]}}, s8};

  // One shared adder for the base-relative operations.
  always_comb begin
    case (op.func)
      iext_pkg::FUNC_REG_DISP: addend = b13;
      iext_pkg::FUNC_SP_IMM6:  addend = any ? b6 : {23'd0, scaled};
      iext_pkg::FUNC_PC_SIGN8: addend = {disp[30:0], 1'b0};
      default:                 addend = '0;
    endcase
  end

  assign sum = op.base_value + addend;

  always_comb begin
    result_value = '0;
    error        = 1'b0;
    pfx_nxt      = pfx;
    case (op.func)
      iext_pkg::FUNC_LOAD_PREFIX: begin
        if (!pfx.first_valid) begin
          pfx_nxt.first_valid = 1'b1;
          pfx_nxt.first_bits  = op.field_bits;
        end else if (!pfx.second_valid) begin
          pfx_nxt.second_valid = 1'b1;
          pfx_nxt.second_bits  = op.field_bits;
        end else begin
          error = 1'b1;
        end
      end
      iext_pkg::FUNC_IMM6: begin
        result_value = b6;
      end
      iext_pkg::FUNC_SIGN6: begin
        result_value = sg6;
      end
      iext_pkg::FUNC_REG_DISP, iext_pkg::FUNC_SP_IMM6, iext_pkg::FUNC_PC_SIGN8: begin
        result_value = sum;
      end
      iext_pkg::FUNC_THREE_OP: begin
        result_value = b13;
        error        = ~any;
      end
      default: begin
      end
    endcase
    // Any value-building operation consumes the pending prefixes.
    if (op.func != iext_pkg::FUNC_LOAD_PREFIX && op.func != iext_pkg::FUNC_NOP) begin
      pfx_nxt.first_valid  = 1'b0;
      pfx_nxt.second_valid = 1'b0;
    end
  end

endmodule

### rtl/immediate_extension_unit.sv
// Top level of the immediate-extension unit: input register, prefix slots and
// result register around the combinational datapath. Depends on iext_pkg and
// iext_datapath.
//
// Usage:
//   Input stream in_*: one operation per transfer (func, field_bits, base_value,
//   access_size packed in in_tdata). Result stream out_*: one transfer per
//   operation, in order (result_value, error packed in out_tdata).
//   A transfer lands in the input register; once the output register is free
//   or drains, the datapath reads it together with the prefix slots, the result
//   goes to the output register and the slots update. Throughput is 1 operation
//   per cycle while the receiver does not stall: the prefix slots are
//   updated in the same cycle an operation moves to the output register, so
//   the next operation sees them at once. The limiting path is the 32-bit add
//   of base and displacement in the datapath.
//   If the receiver stalls (out_tready low) with a result held, the input
//   register fills and then in_tready drops; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) empties both registers and clears both
//   prefix slots.

module immediate_extension_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] func, [15:3] field_bits, [47:16] base_value, [50:48] access_size
  input  logic [iext_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] result_value, [32] error
  output logic [iext_pkg::OUT_DATA_W-1:0]    out_tdata
);

  iext_pkg::op_t            op_r;
  iext_pkg::op_t            op_in;
  logic                     op_valid_r;
  iext_pkg::prefix_state_t  pfx_r;
  iext_pkg::prefix_state_t  pfx_nxt;
  logic [iext_pkg::WORD_W-1:0] res_nxt;
  logic                     err_nxt;
  logic [iext_pkg::WORD_W-1:0] res_r;
  logic                     err_r;
  logic                     out_valid_r;
  logic                     advance;
  logic                     in_xfer;

  // Unpack the input transfer.
  assign op_in.func        = iext_pkg::func_t'(in_tdata[2:0]);
  assign op_in.field_bits  = in_tdata[15:3];
  assign op_in.base_value  = in_tdata[47:16];
  assign op_in.access_size = in_tdata[50:48];

  // Move the held operation forward when the output register is free or drains.
  assign advance   = op_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~op_valid_r | advance;
  assign in_xfer   = in_tvalid & in_tready;

  iext_datapath u_datapath (
    .op           (op_r),
    .pfx          (pfx_r),
    .result_value (res_nxt),
    .error        (err_nxt),
    .pfx_nxt      (pfx_nxt)
  );

  // Control: valid flags and prefix slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pfx_r       <= '0;
    end else begin
      if (in_xfer) begin
        op_valid_r <= 1'b1;
      end else if (advance) begin
        op_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pfx_r       <= pfx_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: operation and result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= op_in;
    end
    if (advance) begin
      res_r <= res_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(iext_pkg::OUT_DATA_W - iext_pkg::OUT_BITS){1'b0}}, err_r, res_r};

  // Slots fill in order, so the second never stands alone.
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    pfx_r.second_valid |-> pfx_r.first_valid)
    else $error("second prefix valid without first");

  // A load into full slots is flagged and leaves them full.
  a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && op_r.func == iext_pkg::FUNC_LOAD_PREFIX && pfx_r.second_valid)
    |=> (err_r && pfx_r.first_valid && pfx_r.second_valid))
    else $error("third prefix not flagged");

  // Three-operand immediate without a prefix is an error.
  a_three_op: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && op_r.func == iext_pkg::FUNC_THREE_OP && !pfx_r.first_valid)
    |=> (err_r && res_r == '0))
    else $error("three-op without prefix not flagged");

  // Value-building operations consume pending prefixes.
  a_consume: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && op_r.func != iext_pkg::FUNC_LOAD_PREFIX
             && op_r.func != iext_pkg::FUNC_NOP)
    |=> (!pfx_r.first_valid && !pfx_r.second_valid))
    else $error("prefixes not cleared after use");

  // A stalled result is not overwritten.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !advance)
    else $error("result overwritten under stall");

endmodule

### test/tb_immediate_extension_unit.sv
// Testbench for immediate_extension_unit: drives operations on the input stream, predicts
// each result from its own model of the prefix slots and checks the result stream.
// Depends on iext_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_immediate_extension_unit;

  localparam int unsigned IDLE_LIMIT = 5000;  // cycles with no transfer on either side
  localparam int unsigned DRAIN_WAIT = 8;     // covers the unit's latency with margin

  typedef struct {
    iext_pkg::func_t op;
    logic [31:0]     value;
    logic            err;
  } ext_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [iext_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [iext_pkg::OUT_DATA_W-1:0] out_tdata;

  // Predicted prefix slots
  logic        slot_a_valid;
  logic [12:0] slot_a_bits;
  logic        slot_b_valid;
  logic [12:0] slot_b_bits;

  ext_result_t pending_results[$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  bit          gaps_on;
  bit          stalls_on;
  int unsigned hold_off_cycles;
  int unsigned stall_left;

  immediate_extension_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Computes the result of one operation and updates the predicted slots.
  function automatic ext_result_t extend_immediate(iext_pkg::func_t op, logic [12:0] fb,
                                                   logic [31:0] base, logic [2:0] acc_size);
    ext_result_t r;
    int unsigned n;
    logic [5:0]  imm6;
    logic [7:0]  s8;
    logic [31:0] wide6;
    logic [31:0] disp13;
    logic [31:0] disp8;
    logic [30:0] wide8;
    r.op    = op;
    r.value = '0;
    r.err   = 1'b0;
    imm6 = fb[5:0];
    s8   = fb[7:0];
    n = slot_b_valid ? 2 : (slot_a_valid ? 1 : 0);
    // imm6 with the prefixes stacked above it
    if (n == 2) wide6 = {slot_a_bits, slot_b_bits, imm6};
    else if (n == 1) wide6 = {13'b0, slot_a_bits, imm6};
    else wide6 = {26'b0, imm6};
    // displacement made of the prefixes alone
    if (n == 2) disp13 = {6'b0, slot_a_bits, slot_b_bits};
    else if (n == 1) disp13 = {19'b0, slot_a_bits};
    else disp13 = '0;
    case (op)
      iext_pkg::FUNC_LOAD_PREFIX: begin
        if (!slot_a_valid) begin
          slot_a_valid = 1'b1;
          slot_a_bits  = fb;
        end else if (!slot_b_valid) begin
          slot_b_valid = 1'b1;
          slot_b_bits  = fb;
        end else begin
          r.err = 1'b1;  // third prefix is dropped
        end
      end
      iext_pkg::FUNC_IMM6: r.value = wide6;
      iext_pkg::FUNC_SIGN6: begin
        if (n == 2) r.value = wide6;
        else if (n == 1) r.value = {{13{slot_a_bits[12]}}, slot_a_bits, imm6};
        else r.value = {{26{imm6[5]}}, imm6};
      end
      iext_pkg::FUNC_REG_DISP: r.value = base + disp13;
      iext_pkg::FUNC_SP_IMM6: begin
        if (n == 0) r.value = base + 32'(imm6) * 32'(acc_size);
        else r.value = base + wide6;
      end
      iext_pkg::FUNC_THREE_OP: begin
        if (n == 0) r.err = 1'b1;
        else r.value = disp13;
      end
      iext_pkg::FUNC_PC_SIGN8: begin
        // top prefix loses its low 3 bits so the displacement fits in 31 bits
        wide8 = {slot_a_bits[12:3], slot_b_bits, s8};
        if (n == 2) disp8 = {wide8[30], wide8};
        else if (n == 1) disp8 = {{11{slot_a_bits[12]}}, slot_a_bits, s8};
        else disp8 = {{24{s8[7]}}, s8};
        r.value = base + {disp8[30:0], 1'b0};
      end
      default: ;  // unused code: no effect
    endcase
    // any value-building operation that finds a prefix uses them up; stale bits stay
    if (op != iext_pkg::FUNC_LOAD_PREFIX && op != iext_pkg::FUNC_NOP && n != 0) begin
      slot_a_valid = 1'b0;
      slot_b_valid = 1'b0;
    end
    return r;
  endfunction

  // Offers one operation and waits for its transfer.
  task automatic send_op(iext_pkg::func_t op, logic [12:0] fb, logic [31:0] base,
                         logic [2:0] acc_size);
    int unsigned gap;
    logic [iext_pkg::IN_DATA_W-1:0] word;
    gap = gaps_on ? pick_gap() : 0;
    word = '0;
    word[2:0]   = op;
    word[15:3]  = fb;
    word[47:16] = base;
    word[50:48] = acc_size;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = word;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(extend_immediate(op, fb, base, acc_size));
  endtask

  function automatic logic [12:0] random_field();
    case ($urandom_range(0, 7))
      0: return 13'h0000;
      1: return 13'h1FFF;
      2: return 13'h1000;
      default: return 13'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_base();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] random_size();
    if ($urandom_range(0, 4) == 0) return 3'($urandom_range(0, 7));
    case ($urandom_range(0, 2))
      0: return 3'd1;
      1: return 3'd2;
      default: return 3'd4;
    endcase
  endfunction

  // Drops the offer so the last accepted item is not taken twice, then waits.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Slot filling, dropped third prefix and the sign extensions
  task automatic test_prefix_slots();
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h1FFF, '0, 3'd1);
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h0000, '0, 3'd1);
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h1555, '0, 3'd1);  // both full: flagged
    send_op(iext_pkg::FUNC_IMM6, 13'h1FFF, 32'hFFFF_FFFF, 3'd7);
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h1000, '0, 3'd1);
    send_op(iext_pkg::FUNC_SIGN6, 13'h0000, '0, 3'd1);       // sign from bit 18
    send_op(iext_pkg::FUNC_SIGN6, 13'h1FE0, '0, 3'd1);       // sign from bit 5, upper bits ignored
  endtask

  // Base-relative, three-operand and no-op operations, with and without prefixes, at the field extremes
  task automatic test_operations();
    send_op(iext_pkg::FUNC_SP_IMM6, 13'h003F, 32'hFFFF_FFFF, 3'd0);  // size 0: no offset
    send_op(iext_pkg::FUNC_SP_IMM6, 13'h003F, 32'hFFFF_FFF0, 3'd7);  // odd size, wraps
    send_op(iext_pkg::FUNC_THREE_OP, 13'h1FFF, 32'hFFFF_FFFF, 3'd4);  // no prefix: error
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h1FFF, '0, 3'd1);
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h1FFF, '0, 3'd1);
    send_op(iext_pkg::FUNC_REG_DISP, 13'h0000, 32'hFFFF_FFFF, 3'd2);
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h0AAA, '0, 3'd1);
    send_op(iext_pkg::FUNC_THREE_OP, 13'h0000, '0, 3'd1);
    send_op(iext_pkg::FUNC_PC_SIGN8, 13'h0080, '0, 3'd1);
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h1FFF, '0, 3'd1);
    send_op(iext_pkg::FUNC_NOP, 13'h1FFF, 32'hFFFF_FFFF, 3'd7);       // prefix must survive
    send_op(iext_pkg::FUNC_PC_SIGN8, 13'h00FF, '0, 3'd1);
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h1FFF, '0, 3'd1);
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h1FFF, '0, 3'd1);
    send_op(iext_pkg::FUNC_PC_SIGN8, 13'h0000, '0, 3'd1);
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h0000, '0, 3'd1);
    send_op(iext_pkg::FUNC_LOAD_PREFIX, 13'h0000, '0, 3'd1);
    send_op(iext_pkg::FUNC_SP_IMM6, 13'h003F, '0, 3'd0);              // prefixed: size unused
  endtask

  // Receiver holds off long while the sender keeps offering back to back
  task automatic test_output_stall();
    int unsigned i;
    gaps_on = 1'b0;
    @(negedge clk);
    in_tvalid = 1'b0;
    hold_off_cycles = 200;
    for (i = 0; i < 20; i++)
      send_op(iext_pkg::func_t'(3'($urandom_range(0, 6))), random_field(), random_base(),
              random_size());
    gaps_on = 1'b1;
  endtask

  // Sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    int unsigned i;
    for (i = 0; i < 5; i++)
      send_op(iext_pkg::func_t'(3'($urandom_range(0, 6))), random_field(), random_base(),
              random_size());
    wait_drained();
    for (i = 0; i < 5; i++)
      send_op(iext_pkg::func_t'(3'($urandom_range(0, 6))), random_field(), random_base(),
              random_size());
  endtask

  // Mostly well-formed prefix runs followed by a consumer, plus noise
  task automatic test_random_sequences(int unsigned count);
    int unsigned sent;
    int unsigned kind;
    int unsigned loads;
    int unsigned i;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 15) == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      kind = $urandom_range(0, 9);
      if (kind == 8) begin
        send_op(iext_pkg::func_t'(3'($urandom_range(0, 7))), random_field(), random_base(),
                random_size());
        sent++;
      end else begin
        if (kind == 9) loads = $urandom_range(3, 4);  // overfilled slots
        else loads = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2);
        for (i = 0; i < loads; i++)
          send_op(iext_pkg::FUNC_LOAD_PREFIX, random_field(), random_base(), random_size());
        send_op(iext_pkg::func_t'(3'($urandom_range(1, 6))), random_field(), random_base(),
                random_size());
        sent += loads + 1;
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Result side: random stalls, plus the long hold-off when asked
  always begin
    @(negedge clk);
    if (hold_off_cycles > 0) begin
      out_tready = 1'b0;
      hold_off_cycles--;
    end else if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    ext_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.value)
          report_mismatch($sformatf("%s result_value exp %h got %h", want.op.name(),
                                    want.value, out_tdata[31:0]));
        if (out_tdata[32] !== want.err)
          report_mismatch($sformatf("%s error exp %b got %b", want.op.name(),
                                    want.err, out_tdata[32]));
      end
    end
  end

  // Watchdog on transfers
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    out_tready      = 1'b0;
    fail_count      = 0;
    idle_cycles     = 0;
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    hold_off_cycles = 0;
    stall_left      = 0;
    slot_a_valid    = 1'b0;
    slot_a_bits     = '0;
    slot_b_valid    = 1'b0;
    slot_b_bits     = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_prefix_slots();
    test_operations();
    test_output_stall();
    test_drain_pause();
    test_random_sequences(800);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
